FILE: rtl/oren_nayar_brdf_eval_defines.svh
// Assertion macros used by the top level of the Oren-Nayar evaluator RTL.
`ifndef OREN_NAYAR_BRDF_EVAL_DEFINES_SVH
`define OREN_NAYAR_BRDF_EVAL_DEFINES_SVH

// Antecedent holds, so the consequent holds in the same cycle.
`define ONB_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("onb assertion failed");

// Antecedent holds, so the consequent holds in the next cycle.
`define ONB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("onb assertion failed");

`endif

FILE: rtl/onb_pkg.sv
// Types and constants of the Oren-Nayar evaluator.
`timescale 1ns / 1ps
package onb_pkg;
  localparam int unsigned DIR_W     = 16;
  localparam int unsigned ZW        = 15;
  localparam int unsigned DW        = 32;
  localparam int unsigned QBITS     = 17;
  localparam int unsigned GW        = 18;
  localparam int unsigned COEF_W    = 16;
  localparam int unsigned PRODB_W   = 34;
  localparam int unsigned INNER_W   = 19;
  localparam int unsigned INV_PI_W  = 15;
  localparam int unsigned IP_W      = 34;
  localparam int unsigned DEN_W     = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [INV_PI_W-1:0] INV_PI = 15'd20861;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_A = 2'd0,
    REG_COEF_B = 2'd1
  } reg_idx_e;

  typedef struct packed {
    logic [DW-1:0]    rem;
    logic [QBITS-1:0] quo;
    logic [ZW-1:0]    zmax;
    logic [DEN_W-1:0] den;
    logic             above;
    logic             gsat;
  } div_t;
endpackage

FILE: rtl/oren_nayar_brdf_eval.sv
// Top level of the pipelined qualitative Oren-Nayar reflectance evaluator.
//
// Queries enter on the input channel (in_valid_i / in_stall_o) and results
// leave on the output channel (out_valid_o / out_stall_i); a transaction
// completes on a clock edge with valid high and stall low.
// The pipeline holds 24 register stages: two front stages, seventeen divider
// stages that each settle one quotient bit of the angular factor, and five
// blend, scale and saturate stages. Throughput is one transaction per cycle
// while the receiver does not stall.
// Each stage keeps its own valid bit, so bubbles close up while the receiver
// stalls, and the input channel stalls only once every stage holds a query.
// The coefficients coef_a and coef_b are written through cfg_we_i, cfg_idx_i and cfg_data_i
// only while the pipeline is empty, a rule for the user that the block does not enforce;
// other indexes are ignored. Reset empties the pipeline and sets coef_a to 1.0 and coef_b to 0.
`timescale 1ns / 1ps
`include "oren_nayar_brdf_eval_defines.svh"
module oren_nayar_brdf_eval #(
  parameter int unsigned COMPONENT_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [onb_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [onb_pkg::COEF_W-1:0]           cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [onb_pkg::DIR_W-1:0]     in_dir_x_i,
  input  logic signed [onb_pkg::DIR_W-1:0]     in_dir_y_i,
  input  logic signed [onb_pkg::DIR_W-1:0]     in_dir_z_i,
  input  logic signed [onb_pkg::DIR_W-1:0]     out_dir_x_i,
  input  logic signed [onb_pkg::DIR_W-1:0]     out_dir_y_i,
  input  logic signed [onb_pkg::DIR_W-1:0]     out_dir_z_i,
  input  logic [COMPONENT_BITS-1:0]            albedo_red_i,
  input  logic [COMPONENT_BITS-1:0]            albedo_green_i,
  input  logic [COMPONENT_BITS-1:0]            albedo_blue_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [COMPONENT_BITS-1:0]            refl_red_o,
  output logic [COMPONENT_BITS-1:0]            refl_green_o,
  output logic [COMPONENT_BITS-1:0]            refl_blue_o,
  output logic [onb_pkg::DEN_W-1:0]            density_o,
  output logic                                 above_surface_o,
  output logic                                 clipped_o
);
  localparam int unsigned CB = COMPONENT_BITS;
  localparam int unsigned NQ = onb_pkg::QBITS;

  logic [onb_pkg::COEF_W-1:0] coef_a_q, coef_b_q;
  logic [NQ:0]                v;
  logic [NQ:0]                st;
  onb_pkg::div_t              dv [NQ+1];
  logic [3*CB-1:0]            alb [NQ+1];
  logic                       shade_stall;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_a_q <= onb_pkg::COEF_W'(32768);
      coef_b_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        onb_pkg::REG_COEF_A: coef_a_q <= cfg_data_i;
        onb_pkg::REG_COEF_B: coef_b_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  onb_front #(.CB(CB)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (in_valid_i),
    .stall_o     (in_stall_o),
    .in_dir_x_i  (in_dir_x_i),
    .in_dir_y_i  (in_dir_y_i),
    .in_dir_z_i  (in_dir_z_i),
    .out_dir_x_i (out_dir_x_i),
    .out_dir_y_i (out_dir_y_i),
    .out_dir_z_i (out_dir_z_i),
    .albedo_i    ({albedo_blue_i, albedo_green_i, albedo_red_i}),
    .valid_o     (v[0]),
    .stall_i     (st[0]),
    .div_o       (dv[0]),
    .albedo_o    (alb[0])
  );

  for (genvar k = 0; k < NQ; k++) begin : g_div
    onb_div_step #(.CB(CB), .BIT(NQ - 1 - k)) u_step (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .valid_i  (v[k]),
      .stall_o  (st[k]),
      .div_i    (dv[k]),
      .albedo_i (alb[k]),
      .valid_o  (v[k+1]),
      .stall_i  (st[k+1]),
      .div_o    (dv[k+1]),
      .albedo_o (alb[k+1])
    );
  end

  assign st[NQ] = shade_stall;

  onb_shade #(.CB(CB)) u_shade (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (v[NQ]),
    .stall_o         (shade_stall),
    .div_i           (dv[NQ]),
    .albedo_i        (alb[NQ]),
    .coef_a_i        (coef_a_q),
    .coef_b_i        (coef_b_q),
    .valid_o         (out_valid_o),
    .stall_i         (out_stall_i),
    .refl_red_o      (refl_red_o),
    .refl_green_o    (refl_green_o),
    .refl_blue_o     (refl_blue_o),
    .density_o       (density_o),
    .above_surface_o (above_surface_o),
    .clipped_o       (clipped_o)
  );

  `ONB_ASSERT_NOW(a_below_zero, out_valid_o && !above_surface_o, refl_red_o == '0 && refl_green_o == '0 && refl_blue_o == '0 && density_o == '0 && !clipped_o)
  `ONB_ASSERT_NOW(a_clip_full, out_valid_o && clipped_o, (&refl_red_o) || (&refl_green_o) || (&refl_blue_o))
  `ONB_ASSERT_NOW(a_stall_full, in_stall_o, out_valid_o && out_stall_i)
  `ONB_ASSERT_NEXT(a_cfg_a, cfg_we_i && cfg_idx_i == onb_pkg::REG_COEF_A, coef_a_q == $past(cfg_data_i))
endmodule

FILE: rtl/onb_front.sv
// Front stages: direction products, surface test, pdf and divider setup.
`timescale 1ns / 1ps
module onb_front #(
  parameter int unsigned CB = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  output logic                               stall_o,
  input  logic signed [onb_pkg::DIR_W-1:0]   in_dir_x_i,
  input  logic signed [onb_pkg::DIR_W-1:0]   in_dir_y_i,
  input  logic signed [onb_pkg::DIR_W-1:0]   in_dir_z_i,
  input  logic signed [onb_pkg::DIR_W-1:0]   out_dir_x_i,
  input  logic signed [onb_pkg::DIR_W-1:0]   out_dir_y_i,
  input  logic signed [onb_pkg::DIR_W-1:0]   out_dir_z_i,
  input  logic [3*CB-1:0]                    albedo_i,
  output logic                               valid_o,
  input  logic                               stall_i,
  output onb_pkg::div_t                      div_o,
  output logic [3*CB-1:0]                    albedo_o
);
  logic signed [onb_pkg::DW-1:0] px_q, px_d, py_q, py_d;
  logic [onb_pkg::ZW-1:0]        zmax_q, zmax_d;
  logic [onb_pkg::DEN_W-1:0]     den_q, den_d;
  logic                          above_q, above_d;
  logic [3*CB-1:0]               alb0_q, alb1_q;
  logic                          v0_q, v1_q;
  logic                          adv0, adv1;
  logic [29:0]                   zprod;
  logic signed [onb_pkg::DW:0]   dsum;
  logic                          dpos;
  onb_pkg::div_t                 div_q, div_d;

  assign adv1    = !v1_q || !stall_i;
  assign adv0    = !v0_q || adv1;
  assign stall_o = !adv0;

  always_comb begin
    px_d    = in_dir_x_i * out_dir_x_i;
    py_d    = in_dir_y_i * out_dir_y_i;
    above_d = !in_dir_z_i[15] && (|in_dir_z_i) && !out_dir_z_i[15] && (|out_dir_z_i);
    zmax_d  = (in_dir_z_i > out_dir_z_i) ? in_dir_z_i[14:0] : out_dir_z_i[14:0];
    zprod   = in_dir_z_i[14:0] * onb_pkg::INV_PI;
    den_d   = {1'b0, zprod[29:15]};
  end

  always_comb begin
    dsum        = {px_q[31], px_q} + {py_q[31], py_q};
    dpos        = !dsum[32] && (|dsum);
    div_d.zmax  = zmax_q;
    div_d.den   = den_q;
    div_d.above = above_q;
    div_d.quo   = '0;
    div_d.gsat  = dpos && (dsum[31:0] >= {zmax_q, 17'b0});
    div_d.rem   = dpos ? dsum[31:0] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else begin
      if (adv0) v0_q <= valid_i;
      if (adv1) v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv0) begin
      px_q    <= px_d;
      py_q    <= py_d;
      zmax_q  <= zmax_d;
      den_q   <= den_d;
      above_q <= above_d;
      alb0_q  <= albedo_i;
    end
    if (adv1) begin
      div_q  <= div_d;
      alb1_q <= alb0_q;
    end
  end

  assign valid_o  = v1_q;
  assign div_o    = div_q;
  assign albedo_o = alb1_q;
endmodule

FILE: rtl/onb_div_step.sv
// One restoring-division stage that settles one quotient bit.
`timescale 1ns / 1ps
module onb_div_step #(
  parameter int unsigned CB  = 16,
  parameter int unsigned BIT = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            stall_o,
  input  onb_pkg::div_t   div_i,
  input  logic [3*CB-1:0] albedo_i,
  output logic            valid_o,
  input  logic            stall_i,
  output onb_pkg::div_t   div_o,
  output logic [3*CB-1:0] albedo_o
);
  logic                   v_q, adv;
  logic [onb_pkg::DW-1:0] trial;
  onb_pkg::div_t          div_q, div_d;
  logic [3*CB-1:0]        alb_q;

  assign adv     = !v_q || !stall_i;
  assign stall_o = !adv;

  always_comb begin
    trial = onb_pkg::DW'(div_i.zmax) << BIT;
    div_d = div_i;
    if (div_i.rem >= trial) begin
      div_d.rem      = div_i.rem - trial;
      div_d.quo[BIT] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (adv) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      div_q <= div_d;
      alb_q <= albedo_i;
    end
  end

  assign valid_o  = v_q;
  assign div_o    = div_q;
  assign albedo_o = alb_q;
endmodule

FILE: rtl/onb_shade.sv
// Back stages: coefficient blend, 1/pi scaling, color products and saturation.
`timescale 1ns / 1ps
module onb_shade #(
  parameter int unsigned CB = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  output logic                        stall_o,
  input  onb_pkg::div_t               div_i,
  input  logic [3*CB-1:0]             albedo_i,
  input  logic [onb_pkg::COEF_W-1:0]  coef_a_i,
  input  logic [onb_pkg::COEF_W-1:0]  coef_b_i,
  output logic                        valid_o,
  input  logic                        stall_i,
  output logic [CB-1:0]               refl_red_o,
  output logic [CB-1:0]               refl_green_o,
  output logic [CB-1:0]               refl_blue_o,
  output logic [onb_pkg::DEN_W-1:0]   density_o,
  output logic                        above_surface_o,
  output logic                        clipped_o
);
  localparam int unsigned NS  = 5;
  localparam int unsigned MW  = CB + onb_pkg::IP_W;
  localparam int unsigned SHW = CB + 1;

  logic [NS-1:0]                 v_q, adv;
  logic [onb_pkg::DEN_W-1:0]     den_q [NS-1];
  logic                          above_q [NS-1];
  logic [3*CB-1:0]               alb_q [3];
  logic [onb_pkg::GW-1:0]        g;
  logic [onb_pkg::PRODB_W-1:0]   prodb_q;
  logic [onb_pkg::INNER_W-1:0]   inner_q;
  logic [onb_pkg::IP_W-1:0]      ip_q;
  logic [MW-1:0]                 m_q [3];
  logic [SHW-1:0]                sh [3];
  logic [CB-1:0]                 ch [3];
  logic [2:0]                    sat;
  logic [CB-1:0]                 red_q, green_q, blue_q;
  logic [onb_pkg::DEN_W-1:0]     dout_q;
  logic                          aout_q, clip_q;

  always_comb begin
    adv[NS-1] = !v_q[NS-1] || !stall_i;
    for (int k = NS - 2; k >= 0; k--) begin
      adv[k] = !v_q[k] || adv[k+1];
    end
  end
  assign stall_o = !adv[0];

  assign g = div_i.gsat ? onb_pkg::GW'(1 << onb_pkg::QBITS) : {1'b0, div_i.quo};

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sh[c]  = SHW'(m_q[c] >> 33);
      sat[c] = sh[c][CB];
      ch[c]  = sat[c] ? {CB{1'b1}} : sh[c][CB-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[0]) v_q[0] <= valid_i;
      for (int k = 1; k < NS; k++) begin
        if (adv[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      prodb_q    <= coef_b_i * g;
      den_q[0]   <= div_i.den;
      above_q[0] <= div_i.above;
      alb_q[0]   <= albedo_i;
    end
    if (adv[1]) begin
      inner_q    <= onb_pkg::INNER_W'(coef_a_i) + onb_pkg::INNER_W'(prodb_q >> 15);
      den_q[1]   <= den_q[0];
      above_q[1] <= above_q[0];
      alb_q[1]   <= alb_q[0];
    end
    if (adv[2]) begin
      ip_q       <= inner_q * onb_pkg::INV_PI;
      den_q[2]   <= den_q[1];
      above_q[2] <= above_q[1];
      alb_q[2]   <= alb_q[1];
    end
    if (adv[3]) begin
      for (int c = 0; c < 3; c++) begin
        m_q[c] <= alb_q[2][c*CB +: CB] * ip_q;
      end
      den_q[3]   <= den_q[2];
      above_q[3] <= above_q[2];
    end
    if (adv[4]) begin
      red_q   <= above_q[3] ? ch[0] : '0;
      green_q <= above_q[3] ? ch[1] : '0;
      blue_q  <= above_q[3] ? ch[2] : '0;
      dout_q  <= above_q[3] ? den_q[3] : '0;
      aout_q  <= above_q[3];
      clip_q  <= above_q[3] && (|sat);
    end
  end

  assign valid_o         = v_q[NS-1];
  assign refl_red_o      = red_q;
  assign refl_green_o    = green_q;
  assign refl_blue_o     = blue_q;
  assign density_o       = dout_q;
  assign above_surface_o = aout_q;
  assign clipped_o       = clip_q;
endmodule

FILE: tb/sv/tb_oren_nayar_brdf_eval.sv
// Self-checking testbench of the pipelined Oren-Nayar reflectance evaluator.
`timescale 1ns / 1ps
module tb_oren_nayar_brdf_eval;
  localparam int unsigned CB = 16;
  localparam int unsigned LATENCY = 24;
  localparam int unsigned WATCHDOG_LIMIT = 20000;

  typedef struct {
    logic signed [15:0] ix, iy, iz, ox, oy, oz;
    logic [CB-1:0] kr, kg, kb;
  } query_t;

  typedef struct {
    logic [CB-1:0] r, g, b;
    logic [15:0] den;
    logic above, clip;
  } refl_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [onb_pkg::CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [onb_pkg::COEF_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [15:0] in_dir_x_i = '0, in_dir_y_i = '0, in_dir_z_i = '0;
  logic signed [15:0] out_dir_x_i = '0, out_dir_y_i = '0, out_dir_z_i = '0;
  logic [CB-1:0] albedo_red_i = '0, albedo_green_i = '0, albedo_blue_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [CB-1:0] refl_red_o, refl_green_o, refl_blue_o;
  logic [15:0] density_o;
  logic above_surface_o, clipped_o;

  oren_nayar_brdf_eval #(.COMPONENT_BITS(CB)) i_dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  query_t pending_q[$];
  refl_t expected_refl_q[$];
  logic [15:0] coef_a_m = 16'd32768, coef_b_m = 16'd0;
  int mismatch_cnt = 0;
  int idle_cycles = 0;
  bit hold_sender = 1'b0;
  bit long_hold = 1'b0;

  function automatic logic [CB-1:0] scale_channel(logic [CB-1:0] kd, logic [63:0] inner,
                                                  inout logic sat);
    logic [63:0] v;
    v = (64'(kd) * inner * 64'd20861) >> 33;
    if (v > 64'((1 << CB) - 1)) begin
      sat = 1'b1;
      return '1;
    end
    return v[CB-1:0];
  endfunction

  function automatic refl_t eval_refl(query_t q);
    refl_t e;
    longint d, zmax, gf;
    logic [63:0] inner;
    logic sat;
    e = '{default: '0};
    if (q.iz <= 0 || q.oz <= 0) return e;
    d = longint'(q.ix) * q.ox + longint'(q.iy) * q.oy;
    zmax = (q.iz > q.oz) ? q.iz : q.oz;
    gf = 0;
    if (d > 0) begin
      gf = d / zmax;
      if (gf > (longint'(4) << 15)) gf = longint'(4) << 15;
    end
    inner = 64'(coef_a_m) + ((64'(coef_b_m) * 64'(gf)) >> 15);
    sat = 1'b0;
    e.r = scale_channel(q.kr, inner, sat);
    e.g = scale_channel(q.kg, inner, sat);
    e.b = scale_channel(q.kb, inner, sat);
    e.den = 16'((64'(q.iz) * 64'd20861) >> 15);
    e.above = 1'b1;
    e.clip = sat;
    return e;
  endfunction

  // Driver: bursts and gaps; the payload holds while stalled.
  int burst_left = 0, gap_left = 0;
  always @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      expected_refl_q.push_back(eval_refl('{in_dir_x_i, in_dir_y_i, in_dir_z_i, out_dir_x_i,
        out_dir_y_i, out_dir_z_i, albedo_red_i, albedo_green_i, albedo_blue_i}));
    end
    if (!(in_valid_i && in_stall_o)) begin
      if (gap_left > 0) gap_left <= gap_left - 1;
      if (!hold_sender && gap_left == 0 && pending_q.size() > 0) begin
        query_t q;
        q = pending_q.pop_front();
        in_valid_i <= 1'b1;
        {in_dir_x_i, in_dir_y_i, in_dir_z_i} <= {q.ix, q.iy, q.iz};
        {out_dir_x_i, out_dir_y_i, out_dir_z_i} <= {q.ox, q.oy, q.oz};
        {albedo_red_i, albedo_green_i, albedo_blue_i} <= {q.kr, q.kg, q.kb};
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 30);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver stall pattern, plus a long hold-off when requested.
  int stall_phase = 0;
  always @(posedge clk_i) begin
    stall_phase <= stall_phase + 1;
    if (long_hold) out_stall_i <= 1'b1;
    else if (stall_phase % 200 < 60) out_stall_i <= 1'b0;
    else out_stall_i <= ($urandom_range(0, 3) == 0);
  end

  // Monitor and watchdog.
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      if (expected_refl_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("unexpected result transaction");
      end else begin
        refl_t e;
        e = expected_refl_q.pop_front();
        if (refl_red_o !== e.r || refl_green_o !== e.g || refl_blue_o !== e.b ||
            density_o !== e.den || above_surface_o !== e.above || clipped_o !== e.clip) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("mismatch exp %h %h %h %h %b %b got %h %h %h %h %b %b",
                     e.r, e.g, e.b, e.den, e.above, e.clip, refl_red_o, refl_green_o,
                     refl_blue_o, density_o, above_surface_o, clipped_o);
        end
      end
    end
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || long_hold)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic logic signed [15:0] rnd_dir();
    case ($urandom_range(0, 5))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sh0000;
      3: return 16'($urandom_range(1, 64));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic query_t rnd_query();
    query_t q;
    q.ix = rnd_dir(); q.iy = rnd_dir(); q.iz = rnd_dir();
    q.ox = rnd_dir(); q.oy = rnd_dir(); q.oz = rnd_dir();
    if ($urandom_range(0, 9) < 8) begin
      q.iz = 16'($urandom_range(1, 32767));
      q.oz = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(1, 300))
                                         : 16'($urandom_range(1, 32767));
    end
    q.kr = CB'($urandom); q.kg = CB'($urandom); q.kb = CB'($urandom);
    if ($urandom_range(0, 7) == 0) q.kr = '1;
    return q;
  endfunction

  task automatic drain_pipe();
    while (pending_q.size() > 0 || in_valid_i || expected_refl_q.size() > 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic write_coef(onb_pkg::reg_idx_e idx, logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == onb_pkg::REG_COEF_A) coef_a_m = val;
    else coef_b_m = val;
  endtask

  initial begin
    logic [15:0] coef_set[5][2];
    coef_set = '{'{16'd32768, 16'd0}, '{16'd0, 16'd32768}, '{16'd65535, 16'd65535},
                 '{16'd25000, 16'd12000}, '{16'd0, 16'd0}};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    // Directed queries with reset coefficients.
    pending_q.push_back('{16'sh7fff, 0, 16'sh7fff, 16'sh7fff, 0, 16'sh7fff, '1, '1, '1});
    pending_q.push_back('{0, 0, 16'sh7fff, 0, 0, 16'sh7fff, '1, 0, 16'h8000});
    pending_q.push_back('{16'sh7fff, 16'sh7fff, 16'sd1, 16'sh7fff, 16'sh7fff, 16'sd1,
                          '1, '1, '1});
    pending_q.push_back('{16'sh8000, 16'sh8000, 16'sd5, 16'sh8000, 16'sh8000, 16'sd9,
                          16'h1234, 16'hffff, 0});
    pending_q.push_back('{16'sh1000, 0, 0, 16'sh1000, 0, 16'sh4000, '1, '1, '1});
    pending_q.push_back('{16'sh1000, 0, 16'sh4000, 16'sh1000, 0, 16'sh8000, '1, '1, '1});
    pending_q.push_back('{16'sh7fff, 0, 16'sh0100, 16'sh8000, 0, 16'sh0100, '1, '1, '1});
    drain_pipe();
    for (int s = 0; s < 5; s++) begin
      write_coef(onb_pkg::REG_COEF_A, coef_set[s][0]);
      write_coef(onb_pkg::REG_COEF_B, coef_set[s][1]);
      pending_q.push_back('{16'sh7fff, 16'sh7fff, 16'sd1, 16'sh7fff, 16'sh7fff, 16'sd2,
                            '1, '1, '1});
      for (int k = 0; k < 80; k++) pending_q.push_back(rnd_query());
      if (s == 2) begin
        // Hold the receiver off so the pipeline fills and the input stalls.
        wait (pending_q.size() < 60);
        long_hold = 1'b1;
        repeat (150) @(posedge clk_i);
        long_hold = 1'b0;
      end
      if (s == 3) begin
        wait (pending_q.size() < 40);
        hold_sender = 1'b1;
        while (in_valid_i || expected_refl_q.size() > 0) @(posedge clk_i);
        hold_sender = 1'b0;
      end
      drain_pipe();
    end
    if (mismatch_cnt == 0 && expected_refl_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

FILE: sim.f
+incdir+rtl
rtl/onb_pkg.sv
rtl/onb_front.sv
rtl/onb_div_step.sv
rtl/onb_shade.sv
rtl/oren_nayar_brdf_eval.sv
tb/sv/tb_oren_nayar_brdf_eval.sv
